FILE: hw/rtl/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg
// Shared types, constants and helpers for the downmixing linear resampler.
// ----------------------------------------------------------------------------
package drs_pkg;

   // Channel lanes carried by one frame
   localparam int MAX_CHANNELS = 8;
   localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);

   // Interpolation lanes: a step of at least one quarter gives at most four outputs
   localparam int LANES  = 4;
   localparam int LCNT_W = $clog2(LANES + 1);

   // Sample and mono formats
   localparam int SMP_W  = 16;
   localparam int MONO_W = 24;
   localparam int SUM_W  = SMP_W + $clog2(MAX_CHANNELS);
   localparam int MAG_W  = SUM_W + 8;

   // Reciprocal divide: q = (mag * floor(2^RECIP_SHIFT / n)) >> RECIP_SHIFT, then fix by one
   localparam int RECIP_SHIFT = 27;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = MAG_W + RECIP_W;

   // Phase formats (unsigned Q4.16)
   localparam int STEP_W = 20;
   localparam int POS_W  = 21;
   localparam int POSX_W = 23;
   localparam int FRAC_W = 16;
   localparam logic [POSX_W-1:0] POS_ONE  = POSX_W'(65536);
   localparam logic [STEP_W-1:0] MIN_STEP = STEP_W'(16384);

   // Configuration registers
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic [3:0]        CCOUNT_RESET = 4'd2;
   localparam logic [STEP_W-1:0] STEP_RESET   = STEP_W'(196608);

   typedef enum logic {
      REG_CHANNEL_COUNT = 1'b0,
      REG_PHASE_STEP    = 1'b1
   } csr_reg_type;

   typedef logic signed [SMP_W-1:0]  sample_type;
   typedef logic signed [MONO_W-1:0] mono_type;

   // Frame sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MIX,
      ST_LANE,
      ST_PUSH
   } state_type;

   // Stage enables handed to the interpolation lanes
   typedef struct packed {
      logic load;
      logic finish;
   } lane_ctrl_type;

   // floor(2^27 / n) for the active channel counts
   function automatic logic [RECIP_W-1:0] drs_recip(input logic [CNT_W-1:0] n);
      logic [RECIP_W-1:0] r;
      case (n)
         CNT_W'(1): r = RECIP_W'(134217728);
         CNT_W'(2): r = RECIP_W'(67108864);
         CNT_W'(3): r = RECIP_W'(44739242);
         CNT_W'(4): r = RECIP_W'(33554432);
         CNT_W'(5): r = RECIP_W'(26843545);
         CNT_W'(6): r = RECIP_W'(22369621);
         CNT_W'(7): r = RECIP_W'(19173961);
         CNT_W'(8): r = RECIP_W'(16777216);
         default:   r = RECIP_W'(134217728);
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/drs_downmix.sv
// ----------------------------------------------------------------------------
// drs_downmix
// Per-channel lanes feed an adder tree; the sum is scaled by 256 and divided
// by the channel count through a reciprocal multiply with a one-step fix.
// ----------------------------------------------------------------------------
module drs_downmix import drs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [CNT_W-1:0]          n,
   input  sample_type                chan [MAX_CHANNELS],
   output logic                      done,
   output mono_type                  mono
);

   logic                    va_ff, va_in;
   logic                    vb_ff, vb_in;
   logic                    done_ff, done_in;
   logic [SUM_W-1:0]        maga_ff, maga_in;
   logic                    nega_ff;
   logic [CNT_W-1:0]        na_ff;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [MAG_W-1:0]        magb_ff;
   logic                    negb_ff;
   logic [CNT_W-1:0]        nb_ff;
   mono_type                mono_ff, mono_in;
   logic signed [SUM_W-1:0] sum;
   logic [MAG_W-1:0]        q_est;
   logic [MAG_W-1:0]        q_fix;
   logic [MAG_W+CNT_W-1:0]  qn;
   logic [MAG_W-1:0]        rem;

   // Mask inactive channels and add the lanes
   always_comb begin
      sum = '0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         if (CNT_W'(c) < n) begin
            sum = sum + SUM_W'(chan[c]);
         end
      end
      maga_in = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
   end

   // Multiply the scaled magnitude by the reciprocal
   assign prod_in = PROD_W'({maga_ff, 8'b0}) * PROD_W'(drs_recip(na_ff));

   // Correct the estimate by one and restore the sign
   always_comb begin
      q_est   = prod_ff[RECIP_SHIFT +: MAG_W];
      qn      = (MAG_W+CNT_W)'(q_est) * (MAG_W+CNT_W)'(nb_ff);
      rem     = magb_ff - qn[MAG_W-1:0];
      q_fix   = (rem >= MAG_W'(nb_ff)) ? q_est + MAG_W'(1) : q_est;
      mono_in = negb_ff ? -mono_type'(q_fix[MONO_W-1:0]) : mono_type'(q_fix[MONO_W-1:0]);
   end

   assign va_in   = start;
   assign vb_in   = va_ff;
   assign done_in = vb_ff;

   // Advance the stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff   <= 1'b0;
         vb_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         va_ff   <= va_in;
         vb_ff   <= vb_in;
         done_ff <= done_in;
      end
   end

   // Hold the stage payloads
   always_ff @(posedge clock) begin
      if (start) begin
         maga_ff <= maga_in;
         nega_ff <= sum[SUM_W-1];
         na_ff   <= n;
      end
      if (va_ff) begin
         prod_ff <= prod_in;
         magb_ff <= {maga_ff, 8'b0};
         negb_ff <= nega_ff;
         nb_ff   <= na_ff;
      end
      if (vb_ff) begin
         mono_ff <= mono_in;
      end
   end

   assign done = done_ff;
   assign mono = mono_ff;

endmodule

FILE: hw/rtl/drs_interp_lane.sv
// ----------------------------------------------------------------------------
// drs_interp_lane
// One interpolation lane: prev + frac * (cur - prev), truncated toward zero
// from Q.24 and clamped to 16 bits. Two stages: multiply, then scale.
// ----------------------------------------------------------------------------
module drs_interp_lane import drs_pkg::*; (
   input  logic              clock,
   input  lane_ctrl_type     ctrl,
   input  logic [FRAC_W-1:0] frac,
   input  mono_type          prev,
   input  mono_type          cur,
   output sample_type        sample
);

   localparam int PW = FRAC_W + MONO_W + 2;
   localparam int AW = PW + 1;
   localparam int QW = AW - 24;

   logic signed [MONO_W:0] diff;
   logic signed [PW-1:0]   fx, dx;
   logic signed [PW-1:0]   prod_ff, prod_in;
   mono_type               prev_ff;
   logic signed [AW-1:0]   acc;
   logic signed [QW-1:0]   q;
   sample_type             sample_ff, sample_in;

   // Multiply the fraction by the sample difference
   always_comb begin
      diff    = (MONO_W+1)'(cur) - (MONO_W+1)'(prev);
      fx      = $signed(PW'({1'b0, frac}));
      dx      = PW'(diff);
      prod_in = fx * dx;
   end

   // Add the base, truncate toward zero, clamp
   always_comb begin
      acc = (AW'(prev_ff) <<< 16) + AW'(prod_ff);
      q   = QW'(acc >>> 24);
      if (acc[AW-1] && (acc[23:0] != 24'd0)) begin
         q = q + QW'(1);
      end
      if (q > QW'(32767)) begin
         sample_in = 16'sh7FFF;
      end else if (q < -QW'(32768)) begin
         sample_in = 16'sh8000;
      end else begin
         sample_in = q[SMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         prod_ff <= prod_in;
         prev_ff <= prev;
      end
      if (ctrl.finish) begin
         sample_ff <= sample_in;
      end
   end

   assign sample = sample_ff;

endmodule

FILE: hw/rtl/drs_out_buf.sv
// ----------------------------------------------------------------------------
// drs_out_buf
// Merges the lane results of one frame into a short shift line and hands
// them out one request at a time, marking the last.
// ----------------------------------------------------------------------------
module drs_out_buf import drs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [LCNT_W-1:0] count,
   input  sample_type        samples [LANES],
   output logic              empty,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sample_type        rsp_out_sample,
   output logic              rsp_run_last
);

   logic [LCNT_W-1:0] cnt_ff, cnt_in;
   sample_type        data_ff [LANES];
   logic              pop;

   assign pop   = (cnt_ff != '0) && !rsp_stall;
   assign empty = (cnt_ff == '0);

   // Load on push, drop one on each taken request
   always_comb begin
      cnt_in = cnt_ff;
      if (push) begin
         cnt_in = count;
      end else if (pop) begin
         cnt_in = cnt_ff - LCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Shift line, front entry is the one on offer
   always_ff @(posedge clock) begin
      if (push) begin
         for (int i = 0; i < LANES; i++) begin
            data_ff[i] <= samples[i];
         end
      end else if (pop) begin
         for (int i = 0; i < LANES - 1; i++) begin
            data_ff[i] <= data_ff[i+1];
         end
      end
   end

   assign rsp_valid      = (cnt_ff != '0);
   assign rsp_out_sample = data_ff[0];
   assign rsp_run_last   = (cnt_ff == LCNT_W'(1));

   a_push_empty : assert property (@(posedge clock) disable iff (reset)
      push |-> cnt_ff == '0)
      else $error("results loaded over pending results");

   a_cnt_range : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LCNT_W'(LANES))
      else $error("result count beyond lane count");

endmodule

FILE: hw/rtl/downmix_linear_resampler.sv
// ----------------------------------------------------------------------------
// downmix_linear_resampler
// Averages up to eight PCM channels to mono and resamples the mono stream by
// linear interpolation with a continuous Q4.16 read position.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_chan0..req_chan7
//   rsp      out        rsp_valid/rsp_stall   rsp_out_sample, rsp_run_last
//   csr      in         APB psel/penable      channel_count @0, phase_step @4
//
// A frame passes through the front end in order: the downmix (adder tree,
// reciprocal multiply, correction), the interpolation lanes (multiply, then
// scale) and the load of the result buffer; a priming frame, or one that
// finds the position already at or past one, ends after the downmix.
// The load waits while the previous frame's results are still being taken,
// so a stalled result side stretches the next frame by that wait.
// Reset is synchronous; it clears the phase, the primed flag and the queue.
// ----------------------------------------------------------------------------
module downmix_linear_resampler import drs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sample_type        req_chan0,
   input  sample_type        req_chan1,
   input  sample_type        req_chan2,
   input  sample_type        req_chan3,
   input  sample_type        req_chan4,
   input  sample_type        req_chan5,
   input  sample_type        req_chan6,
   input  sample_type        req_chan7,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sample_type        rsp_out_sample,
   output logic              rsp_run_last,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   state_type          state_ff, state_in;
   logic [3:0]         ccount_ff;
   logic [STEP_W-1:0]  step_ff;
   mono_type           prev_ff, prev_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               primed_ff, primed_in;
   logic [LCNT_W-1:0]  lcnt_ff, lcnt_in;
   logic               accept;
   logic               csr_wr;
   csr_reg_type        csr_sel;
   logic [CNT_W-1:0]   n_act;
   logic [STEP_W-1:0]  step_sat;
   logic [POSX_W-1:0]  p [LANES+1];
   logic [POSX_W-1:0]  pos_end;
   logic [LCNT_W-1:0]  cnt;
   sample_type         chan [MAX_CHANNELS];
   logic               mix_done;
   mono_type           mono;
   lane_ctrl_type      lane_ctrl;
   sample_type         lane_smp [LANES];
   logic               push;
   logic               buf_empty;
   logic               commit;
   logic               prime;

   assign accept = req_valid && !req_stall;

   // Configuration port
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_sel = csr_reg_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         ccount_ff <= CCOUNT_RESET;
         step_ff   <= STEP_RESET;
      end else if (csr_wr) begin
         case (csr_sel)
            REG_CHANNEL_COUNT: ccount_ff <= pwdata[3:0];
            REG_PHASE_STEP:    step_ff   <= pwdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         REG_CHANNEL_COUNT: prdata = CSR_DW'(ccount_ff);
         REG_PHASE_STEP:    prdata = CSR_DW'(step_ff);
         default:           prdata = '0;
      endcase
   end

   // Saturate the channel count and the step
   always_comb begin
      if (ccount_ff == 4'd0) begin
         n_act = CNT_W'(1);
      end else if (ccount_ff > 4'(MAX_CHANNELS)) begin
         n_act = CNT_W'(MAX_CHANNELS);
      end else begin
         n_act = CNT_W'(ccount_ff);
      end
      step_sat = (step_ff < MIN_STEP) ? MIN_STEP : step_ff;
   end

   // Downmix front end
   assign chan[0] = req_chan0;
   assign chan[1] = req_chan1;
   assign chan[2] = req_chan2;
   assign chan[3] = req_chan3;
   assign chan[4] = req_chan4;
   assign chan[5] = req_chan5;
   assign chan[6] = req_chan6;
   assign chan[7] = req_chan7;

   drs_downmix u_downmix (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .n     (n_act),
      .chan  (chan),
      .done  (mix_done),
      .mono  (mono)
   );

   // Read positions of the lanes and where the phase ends up
   always_comb begin
      p[0] = POSX_W'(pos_ff);
      for (int k = 1; k <= LANES; k++) begin
         p[k] = p[k-1] + POSX_W'(step_sat);
      end
      cnt = '0;
      for (int k = 0; k < LANES; k++) begin
         if (p[k] < POS_ONE) begin
            cnt = cnt + LCNT_W'(1);
         end
      end
      pos_end = p[0];
      for (int k = 1; k <= LANES; k++) begin
         if (cnt == LCNT_W'(k)) begin
            pos_end = p[k];
         end
      end
   end

   // Interpolation lanes
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      drs_interp_lane u_lane (
         .clock  (clock),
         .ctrl   (lane_ctrl),
         .frac   (p[k][FRAC_W-1:0]),
         .prev   (prev_ff),
         .cur    (mono),
         .sample (lane_smp[k])
      );
   end

   // Merge stage and result queue
   drs_out_buf u_out_buf (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .count          (lcnt_ff),
      .samples        (lane_smp),
      .empty          (buf_empty),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_sample (rsp_out_sample),
      .rsp_run_last   (rsp_run_last)
   );

   // Frame sequencer
   always_comb begin
      state_in         = state_ff;
      lane_ctrl.load   = 1'b0;
      lane_ctrl.finish = 1'b0;
      push             = 1'b0;
      commit           = 1'b0;
      prime            = 1'b0;
      req_stall        = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            if (mix_done) begin
               if (!primed_ff) begin
                  prime    = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  commit         = 1'b1;
                  lane_ctrl.load = 1'b1;
                  state_in       = (cnt == '0) ? ST_IDLE : ST_LANE;
               end
            end
         end
         ST_LANE: begin
            lane_ctrl.finish = 1'b1;
            state_in         = ST_PUSH;
         end
         ST_PUSH: begin
            if (buf_empty) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Update the phase, the previous sample and the primed flag
   always_comb begin
      prev_in   = prev_ff;
      pos_in    = pos_ff;
      primed_in = primed_ff;
      lcnt_in   = lcnt_ff;
      if (prime) begin
         prev_in   = mono;
         primed_in = 1'b1;
      end else if (commit) begin
         prev_in = mono;
         pos_in  = POS_W'(pos_end - POS_ONE);
         lcnt_in = cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         prev_ff   <= '0;
         pos_ff    <= '0;
         primed_ff <= 1'b0;
         lcnt_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         prev_ff   <= prev_in;
         pos_ff    <= pos_in;
         primed_ff <= primed_in;
         lcnt_ff   <= lcnt_in;
      end
   end

   a_accept_mix : assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_MIX)
      else $error("accepted request did not start the downmix");

   a_pos_range : assert property (@(posedge clock) disable iff (reset)
      pos_ff[POS_W-1] == 1'b0)
      else $error("read position beyond step range");

   a_push_count : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PUSH |-> lcnt_ff != '0 && primed_ff)
      else $error("empty or unprimed frame reached the result queue");

endmodule
